[design/pnfd_pkg.sv]
// shared constants, opcodes and controller/datapath interface types for the drawing engine
`timescale 1ns / 1ps

package pnfd_pkg;

  localparam int SCREEN_WIDTH  = 160;
  localparam int SCREEN_HEIGHT = 128;

  // bytes in the frame store, two pixels per byte, rounded up for an odd pixel count
  localparam int STORE_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT + 1) / 2;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  // linear pixel index y*width+x
  localparam int PIX_W       = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT) + 1;

  localparam int OP_W   = 3;
  localparam int POS_W  = 10;
  localparam int LEN_W  = 9;
  localparam int COL_W  = 4;
  localparam int DATA_W = 8;
  // walked coordinate: start plus offset, signed
  localparam int CRD_W  = POS_W + 2;
  localparam int SEG_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_FILL_SCREEN   = 3'd0,
    OP_POINT         = 3'd1,
    OP_HLINE         = 3'd2,
    OP_VLINE         = 3'd3,
    OP_FILL_RECT     = 3'd4,
    OP_OUTLINE       = 3'd5,
    OP_OUTLINED_FILL = 3'd6,
    OP_READ          = 3'd7
  } op_t;

  typedef struct packed {
    logic load_cmd;
    logic load_seg;
    logic next_seg;
    logic calc_addr;
    logic mem_read;
    logic mem_write;
    logic step_px;
    logic fill_write;
    logic capture;
    logic publish;
  } cmd_t;

  typedef struct packed {
    op_t  opcode;
    logic seg_empty;
    logic seg_last;
    logic px_last;
    logic px_on;
    logic fill_last;
  } sts_t;

endpackage

[design/pnfd_ram.sv]
// generic single-port ram with registered read
`timescale 1ns / 1ps

module pnfd_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/pnfd_datapath.sv]
// command registers, segment generator, pixel walker, address unit and frame store
`timescale 1ns / 1ps

module pnfd_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  pnfd_pkg::cmd_t                          cmd,
  output pnfd_pkg::sts_t                          sts,
  input  logic [pnfd_pkg::OP_W-1:0]               in_opcode,
  input  logic signed [pnfd_pkg::POS_W-1:0]       in_x_pos,
  input  logic signed [pnfd_pkg::POS_W-1:0]       in_y_pos,
  input  logic [pnfd_pkg::LEN_W-1:0]              in_rect_width,
  input  logic [pnfd_pkg::LEN_W-1:0]              in_rect_height,
  input  logic [pnfd_pkg::COL_W-1:0]              in_color,
  input  logic [pnfd_pkg::COL_W-1:0]              in_outline_color,
  output logic [pnfd_pkg::DATA_W-1:0]             out_read_data,
  output logic                                    out_read_out_of_range
);

  localparam logic [pnfd_pkg::SEG_W-1:0] SEG_TOP      = 3'd0;
  localparam logic [pnfd_pkg::SEG_W-1:0] SEG_BOTTOM   = 3'd1;
  localparam logic [pnfd_pkg::SEG_W-1:0] SEG_LEFT     = 3'd2;
  localparam logic [pnfd_pkg::SEG_W-1:0] SEG_RIGHT    = 3'd3;
  localparam logic [pnfd_pkg::SEG_W-1:0] SEG_INTERIOR = 3'd4;

  // command
  pnfd_pkg::op_t                    opcode_r;
  logic [pnfd_pkg::POS_W-1:0]       x_r, y_r;
  logic [pnfd_pkg::LEN_W-1:0]       w_r, h_r;
  logic [pnfd_pkg::COL_W-1:0]       c_r, oc_r;
  logic [pnfd_pkg::SEG_W-1:0]       seg_idx_r;

  // current segment
  logic [pnfd_pkg::CRD_W-1:0]       seg_x_r, seg_y_r, seg_x_nxt, seg_y_nxt;
  logic [pnfd_pkg::LEN_W-1:0]       seg_w_r, seg_h_r, seg_w_nxt, seg_h_nxt;
  logic [pnfd_pkg::COL_W-1:0]       seg_c_r, seg_c_nxt;
  logic                             seg_empty_r, seg_empty_nxt, seg_short;
  logic [pnfd_pkg::CRD_W-1:0]       xe, ye, we_ext, he_ext;

  // pixel walk
  logic [pnfd_pkg::LEN_W-1:0]       col_r, row_r;
  logic                             col_end, row_end;
  logic [pnfd_pkg::CRD_W-1:0]       px_x, px_y;
  logic                             px_on;
  logic [pnfd_pkg::PIX_W-1:0]       pix;
  logic [pnfd_pkg::ADDR_W-1:0]      addr_r;
  logic                             px_on_r, nib_r;

  // fill sweep and memory port
  logic [pnfd_pkg::ADDR_W-1:0]      fill_cnt_r, ram_addr;
  logic [pnfd_pkg::DATA_W-1:0]      ram_wdata, ram_rdata, merged;
  logic                             ram_we;

  // result
  logic [pnfd_pkg::DATA_W-1:0]      res_data_r, out_data_r;
  logic                             res_oor_r, out_oor_r;

  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      opcode_r <= pnfd_pkg::op_t'(in_opcode);
      x_r      <= in_x_pos;
      y_r      <= in_y_pos;
      w_r      <= in_rect_width;
      h_r      <= in_rect_height;
      c_r      <= in_color;
      oc_r     <= in_outline_color;
    end
  end

  // segment table per command
  assign xe     = {{2{x_r[pnfd_pkg::POS_W-1]}}, x_r};
  assign ye     = {{2{y_r[pnfd_pkg::POS_W-1]}}, y_r};
  assign we_ext = {3'b000, w_r};
  assign he_ext = {3'b000, h_r};

  always_comb begin
    seg_x_nxt = xe;
    seg_y_nxt = ye;
    seg_w_nxt = w_r;
    seg_h_nxt = h_r;
    seg_c_nxt = c_r;
    seg_short = 1'b0;
    unique case (opcode_r)
      pnfd_pkg::OP_FILL_SCREEN, pnfd_pkg::OP_POINT, pnfd_pkg::OP_READ: begin
        seg_w_nxt = 9'd1;
        seg_h_nxt = 9'd1;
      end
      pnfd_pkg::OP_HLINE: begin
        seg_h_nxt = 9'd1;
      end
      pnfd_pkg::OP_VLINE: begin
        seg_w_nxt = 9'd1;
      end
      pnfd_pkg::OP_FILL_RECT: begin
        seg_w_nxt = w_r;
      end
      pnfd_pkg::OP_OUTLINE, pnfd_pkg::OP_OUTLINED_FILL: begin
        if (opcode_r == pnfd_pkg::OP_OUTLINED_FILL) begin
          seg_c_nxt = oc_r;
        end
        unique case (seg_idx_r)
          SEG_TOP: begin
            seg_h_nxt = 9'd1;
          end
          SEG_BOTTOM: begin
            seg_y_nxt = ye + he_ext;
            seg_h_nxt = 9'd1;
          end
          SEG_LEFT: begin
            seg_w_nxt = 9'd1;
          end
          SEG_RIGHT: begin
            seg_x_nxt = xe + we_ext;
            seg_w_nxt = 9'd1;
          end
          default: begin
            // interior, inset by one on every side
            seg_x_nxt = xe + 12'd1;
            seg_y_nxt = ye + 12'd1;
            seg_w_nxt = w_r - 9'd2;
            seg_h_nxt = h_r - 9'd2;
            seg_c_nxt = c_r;
            seg_short = (w_r < 9'd2) || (h_r < 9'd2);
          end
        endcase
      end
    endcase
    seg_empty_nxt = seg_short || (seg_w_nxt == '0) || (seg_h_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_seg) begin
      seg_x_r     <= seg_x_nxt;
      seg_y_r     <= seg_y_nxt;
      seg_w_r     <= seg_w_nxt;
      seg_h_r     <= seg_h_nxt;
      seg_c_r     <= seg_c_nxt;
      seg_empty_r <= seg_empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_idx_r <= '0;
    end else if (cmd.load_cmd) begin
      seg_idx_r <= '0;
    end else if (cmd.next_seg) begin
      seg_idx_r <= seg_idx_r + 3'd1;
    end
  end

  // pixel walker, row by row
  assign col_end = ({1'b0, col_r} + 10'd1) == {1'b0, seg_w_r};
  assign row_end = ({1'b0, row_r} + 10'd1) == {1'b0, seg_h_r};

  always_ff @(posedge clk) begin
    if (cmd.load_seg) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.step_px) begin
      if (col_end) begin
        col_r <= '0;
        row_r <= row_r + 9'd1;
      end else begin
        col_r <= col_r + 9'd1;
      end
    end
  end

  assign px_x  = seg_x_r + {3'b000, col_r};
  assign px_y  = seg_y_r + {3'b000, row_r};
  assign px_on = !px_x[pnfd_pkg::CRD_W-1] && !px_y[pnfd_pkg::CRD_W-1]
              && (px_x < pnfd_pkg::CRD_W'(pnfd_pkg::SCREEN_WIDTH))
              && (px_y < pnfd_pkg::CRD_W'(pnfd_pkg::SCREEN_HEIGHT));
  assign pix   = pnfd_pkg::PIX_W'(px_y[pnfd_pkg::LEN_W-1:0])
               * pnfd_pkg::PIX_W'(pnfd_pkg::SCREEN_WIDTH)
               + pnfd_pkg::PIX_W'(px_x[pnfd_pkg::LEN_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_on_r <= 1'b0;
    end else if (cmd.calc_addr) begin
      px_on_r <= px_on;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_addr) begin
      addr_r <= pnfd_pkg::ADDR_W'(pix >> 1);
      nib_r  <= px_x[0];
    end
  end

  // full-screen sweep counter
  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      fill_cnt_r <= '0;
    end else if (cmd.fill_write) begin
      fill_cnt_r <= fill_cnt_r + pnfd_pkg::ADDR_W'(1);
    end
  end

  // odd column in the high nibble
  assign merged    = nib_r ? {seg_c_r, ram_rdata[3:0]} : {ram_rdata[7:4], seg_c_r};
  assign ram_addr  = cmd.fill_write ? fill_cnt_r : addr_r;
  assign ram_we    = cmd.mem_write || cmd.fill_write;
  assign ram_wdata = cmd.fill_write ? {c_r, c_r} : merged;

  pnfd_ram #(
    .WIDTH (pnfd_pkg::DATA_W),
    .DEPTH (pnfd_pkg::STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (cmd.mem_read),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // result staging and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_data_r <= '0;
      res_oor_r  <= 1'b0;
      out_data_r <= '0;
      out_oor_r  <= 1'b0;
    end else begin
      if (cmd.load_cmd) begin
        res_data_r <= '0;
        res_oor_r  <= 1'b0;
      end else if (cmd.capture) begin
        res_data_r <= px_on_r ? ram_rdata : '0;
        res_oor_r  <= !px_on_r;
      end
      if (cmd.publish) begin
        out_data_r <= res_data_r;
        out_oor_r  <= res_oor_r;
      end
    end
  end

  assign out_read_data         = out_data_r;
  assign out_read_out_of_range = out_oor_r;

  assign sts.opcode    = opcode_r;
  assign sts.seg_empty = seg_empty_r;
  assign sts.seg_last  = (opcode_r == pnfd_pkg::OP_OUTLINE)       ? (seg_idx_r == SEG_RIGHT)
                       : (opcode_r == pnfd_pkg::OP_OUTLINED_FILL) ? (seg_idx_r == SEG_INTERIOR)
                       : 1'b1;
  assign sts.px_last   = col_end && row_end;
  assign sts.px_on     = px_on_r;
  assign sts.fill_last = fill_cnt_r == pnfd_pkg::ADDR_W'(pnfd_pkg::STORE_BYTES - 1);

  a_write_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_write |-> px_on_r)
    else $error("pixel write to an off-screen address");

  a_fill_only_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_write |-> opcode_r == pnfd_pkg::OP_FILL_SCREEN)
    else $error("screen sweep outside a fill-screen command");

  a_oor_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    res_oor_r |-> opcode_r == pnfd_pkg::OP_READ)
    else $error("out-of-range flag on a draw command");

endmodule

[design/pnfd_ctrl.sv]
// controller state machine sequencing segments, pixel read-modify-writes and results
`timescale 1ns / 1ps

module pnfd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output pnfd_pkg::cmd_t cmd,
  input  pnfd_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_SEG_LOAD,
    S_PX_ADDR,
    S_PX_READ,
    S_PX_WRITE,
    S_RD_CAPTURE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_cmd = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = (sts.opcode == pnfd_pkg::OP_FILL_SCREEN) ? S_FILL : S_SEG_LOAD;
      end
      S_FILL: begin
        cmd.fill_write = 1'b1;
        if (sts.fill_last) begin
          state_nxt = S_DONE;
        end
      end
      S_SEG_LOAD: begin
        cmd.load_seg = 1'b1;
        state_nxt    = S_PX_ADDR;
      end
      S_PX_ADDR: begin
        if (sts.seg_empty) begin
          if (sts.seg_last) begin
            state_nxt = S_DONE;
          end else begin
            cmd.next_seg = 1'b1;
            state_nxt    = S_SEG_LOAD;
          end
        end else begin
          cmd.calc_addr = 1'b1;
          state_nxt     = S_PX_READ;
        end
      end
      S_PX_READ: begin
        if (sts.opcode == pnfd_pkg::OP_READ) begin
          cmd.mem_read = 1'b1;
          state_nxt    = S_RD_CAPTURE;
        end else if (sts.px_on) begin
          cmd.mem_read = 1'b1;
          state_nxt    = S_PX_WRITE;
        end else if (!sts.px_last) begin
          cmd.step_px = 1'b1;
          state_nxt   = S_PX_ADDR;
        end else if (sts.seg_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.next_seg = 1'b1;
          state_nxt    = S_SEG_LOAD;
        end
      end
      S_PX_WRITE: begin
        cmd.mem_write = 1'b1;
        if (!sts.px_last) begin
          cmd.step_px = 1'b1;
          state_nxt   = S_PX_ADDR;
        end else if (sts.seg_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.next_seg = 1'b1;
          state_nxt    = S_SEG_LOAD;
        end
      end
      S_RD_CAPTURE: begin
        cmd.capture = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_DECODE)
    else $error("accepted command not decoded");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PX_WRITE |-> $past(state_r) == S_PX_READ)
    else $error("pixel write without a preceding read");

  a_done_publishes: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == S_DONE && state_r == S_IDLE |-> out_valid_r)
    else $error("command finished without a result");

endmodule

[design/packed_nibble_framebuffer_draw.sv]
// top level of the 4-bit packed frame store drawing engine
`timescale 1ns / 1ps

// usage
// - input channel: in_valid / in_stall with one command per transaction
//   (fill screen, point, hline, vline, fill rect, outline, outlined fill, read)
// - result channel: out_valid / out_stall, exactly one result transaction per
//   command; read_data and read_out_of_range are zero for draw commands
// - one command at a time: in_stall stays high from acceptance until the
//   result has been loaded into the output register
// - steps: decode, a load per shape segment (and an address step for an
//   empty one), per pixel address and read when clipped or address, read
//   and write when on screen, then a closing step that loads the result;
//   the single frame store port keeps the read and the write apart
// - fill screen sweeps every byte, one a cycle
// - off-screen reads give out_of_range and no data
// - the output register lets a new command be taken while the last result
//   still waits; a stalled receiver only holds the engine at its final step
// - reset clears the controller and output valid; the frame store keeps no
//   reset and must be written (fill screen) before it is read

module packed_nibble_framebuffer_draw (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pnfd_pkg::OP_W-1:0]         in_opcode,
  input  logic signed [pnfd_pkg::POS_W-1:0] in_x_pos,
  input  logic signed [pnfd_pkg::POS_W-1:0] in_y_pos,
  input  logic [pnfd_pkg::LEN_W-1:0]        in_rect_width,
  input  logic [pnfd_pkg::LEN_W-1:0]        in_rect_height,
  input  logic [pnfd_pkg::COL_W-1:0]        in_color,
  input  logic [pnfd_pkg::COL_W-1:0]        in_outline_color,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pnfd_pkg::DATA_W-1:0]       out_read_data,
  output logic                              out_read_out_of_range
);

  // control between sequencer and datapath
  pnfd_pkg::cmd_t cmd;
  pnfd_pkg::sts_t sts;

  pnfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // command capture, shape walk, frame store and result register
  pnfd_datapath u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_opcode             (in_opcode),
    .in_x_pos              (in_x_pos),
    .in_y_pos              (in_y_pos),
    .in_rect_width         (in_rect_width),
    .in_rect_height        (in_rect_height),
    .in_color              (in_color),
    .in_outline_color      (in_outline_color),
    .out_read_data         (out_read_data),
    .out_read_out_of_range (out_read_out_of_range)
  );

endmodule
